// File: hw/rtl/alu8_pkg.sv
// Shared types and operation codes for the 8-bit ALU with Z N H C flags.
// No dependencies; used by alu8_core, the top level and the checker.

package alu8_pkg;

    localparam logic [4:0] FUNC_ADD  = 5'd0;
    localparam logic [4:0] FUNC_ADC  = 5'd1;
    localparam logic [4:0] FUNC_SUB  = 5'd2;
    localparam logic [4:0] FUNC_SBC  = 5'd3;
    localparam logic [4:0] FUNC_AND  = 5'd4;
    localparam logic [4:0] FUNC_OR   = 5'd5;
    localparam logic [4:0] FUNC_XOR  = 5'd6;
    localparam logic [4:0] FUNC_CP   = 5'd7;
    localparam logic [4:0] FUNC_INC  = 5'd8;
    localparam logic [4:0] FUNC_DEC  = 5'd9;
    localparam logic [4:0] FUNC_SWAP = 5'd10;
    localparam logic [4:0] FUNC_DAA  = 5'd11;
    localparam logic [4:0] FUNC_RLC  = 5'd12;
    localparam logic [4:0] FUNC_RRC  = 5'd13;
    localparam logic [4:0] FUNC_RL   = 5'd14;
    localparam logic [4:0] FUNC_RR   = 5'd15;
    localparam logic [4:0] FUNC_SLA  = 5'd16;
    localparam logic [4:0] FUNC_SRA  = 5'd17;
    localparam logic [4:0] FUNC_SRL  = 5'd18;
    localparam logic [4:0] FUNC_BIT  = 5'd19;
    localparam logic [4:0] FUNC_SET  = 5'd20;
    localparam logic [4:0] FUNC_RES  = 5'd21;

    // Flag positions inside a packed flag nibble
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0] func;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [2:0] bit_index;
        logic [3:0] flags_in;
    } alu_in_t;

    typedef struct packed {
        logic [7:0] result;
        logic [3:0] flags_out;
        logic       write_back;
    } alu_out_t;

endpackage

// File: hw/rtl/cpu_8bit_alu_with_flags_top.sv
// Top level of the 8-bit ALU with Z N H C flags: input register, datapath, result register.
// Depends on alu8_pkg and alu8_core.
//
//   channel   handshake        payload     accepted when
//   -------   --------------   ---------   ------------------------------
//   command   start / busy     cmd         start high and busy low
//   result    done (strobe)    rsp         every cycle done is high
//
// One operation word enters per clock; busy stays low. The word is captured in
// the input register, passes the datapath and lands in the result register, so
// its result shows on rsp with done straight from the result register, for one
// cycle only. rst_n clears both valid flags at once; payload registers are not reset.
// The receiver cannot stall, so nothing ever holds the pipeline.

module cpu_8bit_alu_with_flags_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  alu8_pkg::alu_in_t  cmd,
    output logic               done,
    output alu8_pkg::alu_out_t rsp
);

    logic               in_valid_reg;
    alu8_pkg::alu_in_t  in_reg;
    logic               out_valid_reg;
    alu8_pkg::alu_out_t out_reg;
    alu8_pkg::alu_out_t out_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            in_reg <= cmd;
        if (in_valid_reg)
            out_reg <= out_next;
    end

    alu8_core u_core (
        .cmd (in_reg),
        .rsp (out_next)
    );

    assign done = out_valid_reg;
    assign rsp  = out_reg;

endmodule

// File: hw/rtl/alu8_core.sv
// Combinational datapath of the 8-bit ALU: one operation word in, one result word out.
// Depends on alu8_pkg for the word types and operation codes.

module alu8_core (
    input  alu8_pkg::alu_in_t  cmd,
    output alu8_pkg::alu_out_t rsp
);

    logic [7:0] a;
    logic [7:0] b;
    logic [3:0] f;
    logic       cin;
    logic       c_use;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] dif9;
    logic [4:0] dif5;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic       daa_c1;
    logic [7:0] daa_r1;
    logic       daa_cf;
    logic       daa_c2;
    logic [7:0] daa_r2;
    logic [7:0] bit_mask;
    logic [7:0] r;
    logic [3:0] nf;
    logic       wb;

    assign a   = cmd.operand_a;
    assign b   = cmd.operand_b;
    assign f   = cmd.flags_in;
    assign cin = f[alu8_pkg::FLAG_C];

    // carry or borrow enters only for adc and sbc
    assign c_use = ((cmd.func == alu8_pkg::FUNC_ADC) || (cmd.func == alu8_pkg::FUNC_SBC)) & cin;

    assign sum9 = {1'b0, a} + {1'b0, b} + {8'd0, c_use};
    assign sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_use};
    assign dif9 = {1'b0, a} - {1'b0, b} - {8'd0, c_use};
    assign dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_use};

    assign inc_r = a + 8'd1;
    assign dec_r = a - 8'd1;

    // decimal adjust: low-nibble fix first, then high-nibble fix on the adjusted value
    assign daa_c1 = (a[3:0] > 4'd9) || f[alu8_pkg::FLAG_H];
    always_comb
    begin
        if (f[alu8_pkg::FLAG_N])
        begin
            daa_r1 = daa_c1 ? (a - 8'h06) : a;
            daa_cf = daa_c1 ? (daa_r1[7:4] == 4'hF) : f[alu8_pkg::FLAG_C];
        end
        else
        begin
            daa_r1 = daa_c1 ? (a + 8'h06) : a;
            daa_cf = daa_c1 ? (daa_r1[7:4] == 4'h0) : f[alu8_pkg::FLAG_C];
        end
        daa_c2 = (daa_r1[7:4] > 4'h9) || daa_cf;
        if (!daa_c2)
            daa_r2 = daa_r1;
        else if (f[alu8_pkg::FLAG_N])
            daa_r2 = daa_r1 - 8'h60;
        else
            daa_r2 = daa_r1 + 8'h60;
    end

    assign bit_mask = 8'd1 << cmd.bit_index;

    always_comb
    begin
        r  = a;
        nf = f;
        wb = 1'b1;
        unique case (cmd.func)
            alu8_pkg::FUNC_ADD, alu8_pkg::FUNC_ADC:
            begin
                r  = sum9[7:0];
                nf = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
            end
            alu8_pkg::FUNC_SUB, alu8_pkg::FUNC_SBC:
            begin
                r  = dif9[7:0];
                nf = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
            end
            alu8_pkg::FUNC_CP:
            begin
                nf = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
                wb = 1'b0;
            end
            alu8_pkg::FUNC_AND:
            begin
                r  = a & b;
                nf = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            alu8_pkg::FUNC_OR:
            begin
                r  = a | b;
                nf = {(a | b) == 8'd0, 3'b000};
            end
            alu8_pkg::FUNC_XOR:
            begin
                r  = a ^ b;
                nf = {(a ^ b) == 8'd0, 3'b000};
            end
            alu8_pkg::FUNC_INC:
            begin
                r  = inc_r;
                nf = {inc_r == 8'd0, 1'b0, a[3:0] == 4'hF, f[alu8_pkg::FLAG_C]};
            end
            alu8_pkg::FUNC_DEC:
            begin
                r  = dec_r;
                nf = {dec_r == 8'd0, 1'b1, a[3:0] == 4'h0, f[alu8_pkg::FLAG_C]};
            end
            alu8_pkg::FUNC_SWAP:
            begin
                r  = {a[3:0], a[7:4]};
                nf = {a == 8'd0, 3'b000};
            end
            alu8_pkg::FUNC_DAA:
            begin
                r  = daa_r2;
                nf = {daa_r2 == 8'd0, f[alu8_pkg::FLAG_N], f[alu8_pkg::FLAG_H], daa_cf};
            end
            alu8_pkg::FUNC_RLC:
            begin
                r  = {a[6:0], a[7]};
                nf = {a == 8'd0, 2'b00, a[7]};
            end
            alu8_pkg::FUNC_RRC:
            begin
                r  = {a[0], a[7:1]};
                nf = {a == 8'd0, 2'b00, a[0]};
            end
            alu8_pkg::FUNC_RL:
            begin
                r  = {a[6:0], cin};
                nf = {{a[6:0], cin} == 8'd0, 2'b00, a[7]};
            end
            alu8_pkg::FUNC_RR:
            begin
                r  = {cin, a[7:1]};
                nf = {{cin, a[7:1]} == 8'd0, 2'b00, a[0]};
            end
            alu8_pkg::FUNC_SLA:
            begin
                r  = {a[6:0], 1'b0};
                nf = {a[6:0] == 7'd0, 2'b00, a[7]};
            end
            alu8_pkg::FUNC_SRA:
            begin
                r  = {a[7], a[7:1]};
                nf = {a[7:1] == 7'd0, 2'b00, a[0]};
            end
            alu8_pkg::FUNC_SRL:
            begin
                r  = {1'b0, a[7:1]};
                nf = {a[7:1] == 7'd0, 2'b00, a[0]};
            end
            alu8_pkg::FUNC_BIT:
            begin
                nf = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, f[alu8_pkg::FLAG_C]};
                wb = 1'b0;
            end
            alu8_pkg::FUNC_SET:
                r = a | bit_mask;
            alu8_pkg::FUNC_RES:
                r = a & ~bit_mask;
            default:
                // pass the operand and flags through, store nothing
                wb = 1'b0;
        endcase
    end

    assign rsp.result     = r;
    assign rsp.flags_out  = nf;
    assign rsp.write_back = wb;

endmodule

// File: hw/rtl/alu8_checker.sv
// Port-level checks for the 8-bit ALU top level, attached by the bind at the end.
// Depends on alu8_pkg.

module alu8_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input alu8_pkg::alu_in_t  cmd,
    input logic               done,
    input alu8_pkg::alu_out_t rsp
);

    // every accepted word yields a result strobe on done
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted word produced no result");

    // no result without an earlier accepted word
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without accepted word");

    // compare, bit test and unknown codes never store
    a_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd.func, 2) == alu8_pkg::FUNC_CP
                  || $past(cmd.func, 2) == alu8_pkg::FUNC_BIT
                  || $past(cmd.func, 2) > alu8_pkg::FUNC_RES))
        |-> !rsp.write_back)
        else $error("write_back set for a non-storing operation");

    // compare returns operand_a untouched
    a_cp_keeps_a: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.func, 2) == alu8_pkg::FUNC_CP)
        |-> rsp.result == $past(cmd.operand_a, 2))
        else $error("compare changed the operand");

    // set and reset keep all flags
    a_setres_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd.func, 2) == alu8_pkg::FUNC_SET
                  || $past(cmd.func, 2) == alu8_pkg::FUNC_RES))
        |-> rsp.flags_out == $past(cmd.flags_in, 2))
        else $error("set or reset altered the flags");

endmodule

bind cpu_8bit_alu_with_flags_top alu8_checker u_alu8_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);

// File: sim/tb.sv
// Self-checking testbench for the 8-bit ALU with Z N H C flags.
// Depends on alu8_pkg and cpu_8bit_alu_with_flags_top; drives bursty command words and checks
// every result against a local flag and result predictor.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_WORDS   = 1800;
    localparam logic [4:0] FUNC_UNUSED_TOP = 5'd31;

    typedef struct {
        alu8_pkg::alu_in_t word;
        logic              drain;
    } pending_op_t;

    typedef struct {
        alu8_pkg::alu_in_t  word;
        alu8_pkg::alu_out_t want;
    } expected_op_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    alu8_pkg::alu_in_t  cmd = '0;
    logic               done;
    alu8_pkg::alu_out_t rsp;

    pending_op_t  pending_ops[$];
    expected_op_t expected_results[$];

    logic taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 1;
    int   words_sent = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   drain_pauses = 0;

    cpu_8bit_alu_with_flags_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Compute result byte, flags and write-back for one command word
    function automatic alu8_pkg::alu_out_t alu_predict(alu8_pkg::alu_in_t w);
        alu8_pkg::alu_out_t o;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] r;
        logic [3:0] f;
        logic [3:0] nf;
        logic [8:0] sum;
        logic       cin;
        logic       wb;
        int         c;
        a   = w.operand_a;
        b   = w.operand_b;
        f   = w.flags_in;
        cin = f[alu8_pkg::FLAG_C];
        r   = a;
        nf  = f;
        wb  = 1'b1;
        case (w.func)
            alu8_pkg::FUNC_ADD, alu8_pkg::FUNC_ADC:
            begin
                c = (w.func == alu8_pkg::FUNC_ADC) ? int'(cin) : 0;
                sum = {1'b0, a} + {1'b0, b} + 9'(c);
                r = sum[7:0];
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
                nf[alu8_pkg::FLAG_H] = (int'(a[3:0]) + int'(b[3:0]) + c) > 15;
                nf[alu8_pkg::FLAG_C] = sum[8];
            end
            alu8_pkg::FUNC_SUB, alu8_pkg::FUNC_SBC, alu8_pkg::FUNC_CP:
            begin
                c = (w.func == alu8_pkg::FUNC_SBC) ? int'(cin) : 0;
                r = a - b - 8'(c);
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
                nf[alu8_pkg::FLAG_N] = 1'b1;
                nf[alu8_pkg::FLAG_H] = int'(a[3:0]) < int'(b[3:0]) + c;
                nf[alu8_pkg::FLAG_C] = int'(a) < int'(b) + c;
                if (w.func == alu8_pkg::FUNC_CP)
                begin
                    r = a;
                    wb = 1'b0;
                end
            end
            alu8_pkg::FUNC_AND:
            begin
                r = a & b;
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
                nf[alu8_pkg::FLAG_H] = 1'b1;
            end
            alu8_pkg::FUNC_OR, alu8_pkg::FUNC_XOR, alu8_pkg::FUNC_SWAP:
            begin
                if (w.func == alu8_pkg::FUNC_OR)
                    r = a | b;
                else if (w.func == alu8_pkg::FUNC_XOR)
                    r = a ^ b;
                else
                    r = {a[3:0], a[7:4]};
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
            end
            alu8_pkg::FUNC_INC, alu8_pkg::FUNC_DEC:
            begin
                r = (w.func == alu8_pkg::FUNC_INC) ? a + 8'd1 : a - 8'd1;
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
                nf[alu8_pkg::FLAG_N] = (w.func == alu8_pkg::FUNC_DEC);
                nf[alu8_pkg::FLAG_H] = (w.func == alu8_pkg::FUNC_INC) ? (a[3:0] == 4'hF)
                                                                      : (a[3:0] == 4'h0);
                nf[alu8_pkg::FLAG_C] = f[alu8_pkg::FLAG_C];
            end
            alu8_pkg::FUNC_DAA:
            begin
                // Low-nibble fix first; it decides C, which then gates the high fix
                if (a[3:0] > 4'd9 || f[alu8_pkg::FLAG_H])
                begin
                    r = f[alu8_pkg::FLAG_N] ? r - 8'h06 : r + 8'h06;
                    nf[alu8_pkg::FLAG_C] = f[alu8_pkg::FLAG_N] ? (r[7:4] == 4'hF)
                                                               : (r[7:4] == 4'h0);
                end
                if (r[7:4] > 4'd9 || nf[alu8_pkg::FLAG_C])
                    r = f[alu8_pkg::FLAG_N] ? r - 8'h60 : r + 8'h60;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
            end
            alu8_pkg::FUNC_RLC, alu8_pkg::FUNC_RRC, alu8_pkg::FUNC_RL, alu8_pkg::FUNC_RR,
            alu8_pkg::FUNC_SLA, alu8_pkg::FUNC_SRA, alu8_pkg::FUNC_SRL:
            begin
                case (w.func)
                    alu8_pkg::FUNC_RLC: r = {a[6:0], a[7]};
                    alu8_pkg::FUNC_RRC: r = {a[0], a[7:1]};
                    alu8_pkg::FUNC_RL:  r = {a[6:0], cin};
                    alu8_pkg::FUNC_RR:  r = {cin, a[7:1]};
                    alu8_pkg::FUNC_SLA: r = {a[6:0], 1'b0};
                    alu8_pkg::FUNC_SRA: r = {a[7], a[7:1]};
                    default:            r = {1'b0, a[7:1]};
                endcase
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = (r == 8'h00);
                if (w.func == alu8_pkg::FUNC_RLC || w.func == alu8_pkg::FUNC_RL ||
                    w.func == alu8_pkg::FUNC_SLA)
                    nf[alu8_pkg::FLAG_C] = a[7];
                else
                    nf[alu8_pkg::FLAG_C] = a[0];
            end
            alu8_pkg::FUNC_BIT:
            begin
                wb = 1'b0;
                nf = '0;
                nf[alu8_pkg::FLAG_Z] = ~a[w.bit_index];
                nf[alu8_pkg::FLAG_H] = 1'b1;
                nf[alu8_pkg::FLAG_C] = f[alu8_pkg::FLAG_C];
            end
            alu8_pkg::FUNC_SET:
                r = a | (8'h01 << w.bit_index);
            alu8_pkg::FUNC_RES:
                r = a & ~(8'h01 << w.bit_index);
            default:
                wb = 1'b0;
        endcase
        o.result     = r;
        o.flags_out  = nf;
        o.write_back = wb;
        return o;
    endfunction

    task automatic queue_op(logic [4:0] func, logic [7:0] a, logic [7:0] b,
                            logic [2:0] bi, logic [3:0] f, logic drain);
        pending_op_t p;
        p.word.func      = func;
        p.word.operand_a = a;
        p.word.operand_b = b;
        p.word.bit_index = bi;
        p.word.flags_in  = f;
        p.drain          = drain;
        pending_ops.push_back(p);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[8];
        corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h01, 8'h99, 8'h9A};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return 8'($urandom());
    endfunction

    // Driver: present a new word on the falling edge once the last one was taken
    always @(negedge clk)
    begin
        pending_op_t nxt;
        logic        next_start;
        if (rst_n)
        begin
            next_start = start;
            if (!start || taken)
            begin
                next_start = 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (pending_ops.size() > 0 &&
                         !(pending_ops[0].drain && expected_results.size() > 0))
                begin
                    nxt = pending_ops.pop_front();
                    cmd <= nxt.word;
                    next_start = 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            start <= next_start;
        end
    end

    // Monitor: record accepted words, check results, run the watchdog
    always @(posedge clk)
    begin
        expected_op_t       e;
        alu8_pkg::alu_out_t want;
        logic               hit;
        if (rst_n)
        begin
            hit = 1'b0;
            taken <= start && !busy;
            if (start && !busy)
            begin
                hit = 1'b1;
                e.word = cmd;
                e.want = alu_predict(cmd);
                expected_results.push_back(e);
                words_sent <= words_sent + 1;
            end
            if (done)
            begin
                hit = 1'b1;
                results_checked <= results_checked + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_LIMIT)
                        $display("tb: unexpected result %02h flags %h wb %b",
                                 rsp.result, rsp.flags_out, rsp.write_back);
                end
                else
                begin
                    e = expected_results.pop_front();
                    want = e.want;
                    if (rsp.result !== want.result || rsp.flags_out !== want.flags_out ||
                        rsp.write_back !== want.write_back)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("tb: mismatch func %0d a %02h b %02h bit %0d f %h",
                                     e.word.func, e.word.operand_a, e.word.operand_b,
                                     e.word.bit_index, e.word.flags_in);
                            $display("tb:   got %02h/%h/%b want %02h/%h/%b",
                                     rsp.result, rsp.flags_out, rsp.write_back,
                                     want.result, want.flags_out, want.write_back);
                        end
                    end
                end
            end
            idle_cycles <= hit ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [4:0] fn;
        // Directed corners: carry-in into H and C, kept C on inc/dec, daa both ways
        queue_op(alu8_pkg::FUNC_ADD,  8'hFF, 8'h01, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_ADC,  8'hFF, 8'h00, 3'd0, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_ADC,  8'h0F, 8'h00, 3'd0, 4'hF, 1'b0);
        queue_op(alu8_pkg::FUNC_SUB,  8'h00, 8'h01, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_SBC,  8'h10, 8'h0F, 3'd0, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_SBC,  8'h00, 8'hFF, 3'd0, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_AND,  8'hFF, 8'h00, 3'd0, 4'hF, 1'b0);
        queue_op(alu8_pkg::FUNC_OR,   8'h00, 8'h00, 3'd0, 4'hF, 1'b0);
        queue_op(alu8_pkg::FUNC_XOR,  8'hFF, 8'hFF, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_CP,   8'h3C, 8'h3C, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_INC,  8'hFF, 8'h00, 3'd0, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_DEC,  8'h00, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_SWAP, 8'hF0, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_DAA,  8'h9A, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_DAA,  8'h00, 8'h00, 3'd0, 4'h6, 1'b0);
        queue_op(alu8_pkg::FUNC_RLC,  8'h80, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_RRC,  8'h01, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_RL,   8'h80, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_RR,   8'h01, 8'h00, 3'd0, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_SLA,  8'h80, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_SRA,  8'h81, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_SRL,  8'h01, 8'h00, 3'd0, 4'h0, 1'b0);
        queue_op(alu8_pkg::FUNC_BIT,  8'h7F, 8'h00, 3'd7, 4'h1, 1'b0);
        queue_op(alu8_pkg::FUNC_SET,  8'h00, 8'h00, 3'd7, 4'hA, 1'b0);
        queue_op(alu8_pkg::FUNC_RES,  8'hFF, 8'hFF, 3'd0, 4'h5, 1'b0);
        queue_op(FUNC_UNUSED_TOP,     8'hA5, 8'h5A, 3'd3, 4'hC, 1'b0);
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // Mostly legal operations, a few unknown codes mixed in
            if ($urandom_range(0, 19) == 0)
                fn = 5'($urandom_range(int'(alu8_pkg::FUNC_RES) + 1, int'(FUNC_UNUSED_TOP)));
            else
                fn = 5'($urandom_range(int'(alu8_pkg::FUNC_ADD), int'(alu8_pkg::FUNC_RES)));
            queue_op(fn, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)), (i % 300) == 0);
        end
        drain_pauses = (RANDOM_WORDS + 299) / 300;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d words sent, %0d results checked, %0d mismatches", words_sent,
                 results_checked, mismatches);
        $display("tb: covered all 22 operations, unknown codes, %0d drain pauses",
                 drain_pauses);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
